FILE: design/nntb_pkg.sv
// Package for the nearest-neighbour tour builder: field widths, codes, sequencer states.
`default_nettype none
package nntb_pkg;

  localparam int DEF_MAX_CITIES  = 32;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int CITY_FIELD_BITS = 5;
  localparam int POS_BITS        = 5;
  localparam int COUNT_BITS      = 6;
  localparam int EDGE_FIELD_BITS = 16;
  localparam int TOUR_BITS       = 22;
  localparam int CLAMP_BITS      = COUNT_BITS + 2;

  localparam int CEIL_BITS = 30;
  localparam longint unsigned SEARCH_CEILING = 64'd1000000000;

  localparam logic [TOUR_BITS-1:0]  TOUR_WEIGHT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CITY_COUNT_RESET = 6'd32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_ADJ_RD1,
    S_ADJ_RD2,
    S_ADJ_ADD2,
    S_ADJ_HSUM,
    S_ADJ_DIFF,
    S_ADJ_SAT,
    S_EMIT_RD,
    S_EMIT_PUT
  } state_t;

endpackage
`default_nettype wire

FILE: design/nearest_neighbour_tour_builder.sv
// Nearest-neighbour tour builder: weight matrix, greedy scan sequencer, edge swap, emit.
`default_nettype none
// A load item writes one weight matrix entry. A run item builds a greedy path over the
// first city_count cities (n; 0 acts as one city, larger counts clamp to MAX_CITIES)
// and emits n result items. The scan reads one matrix entry per cycle from the weight
// memory; each of the n-1 path steps scans the current city's row, drains the last
// read and commits the nearest unvisited city. Weight adjustment follows, then each
// city is read from the path store and put out, waiting while the output stalls. One
// shared adder serves the running sum and the final adjustment. No item is taken
// while a run is in progress; a result item waits in an output register.
module nearest_neighbour_tour_builder
  import nntb_pkg::*;
#(
  parameter int MAX_CITIES  = DEF_MAX_CITIES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire  logic                       clk,
  input  wire  logic                       rst,
  input  wire  logic                       cfg_we,
  input  wire  logic [COUNT_BITS-1:0]      cfg_wdata,
  input  wire  logic                       item_valid,
  output logic                             item_stall,
  input  wire  logic                       op,
  input  wire  logic [CITY_FIELD_BITS-1:0] from_city,
  input  wire  logic [CITY_FIELD_BITS-1:0] to_city,
  input  wire  logic [EDGE_FIELD_BITS-1:0] edge_weight,
  output logic                             result_valid,
  input  wire  logic                       result_stall,
  output logic [POS_BITS-1:0]              position,
  output logic [CITY_FIELD_BITS-1:0]       city,
  output logic [TOUR_BITS-1:0]             tour_weight,
  output logic                             last
);

  localparam int CITY_BITS = $clog2(MAX_CITIES);
  localparam int CNT_BITS  = $clog2(MAX_CITIES + 1);
  localparam int MAT_DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int ADDR_BITS = $clog2(MAT_DEPTH);
  localparam int BEST_BITS = (WEIGHT_BITS > CEIL_BITS) ? WEIGHT_BITS : CEIL_BITS;
  localparam int ACC_BITS  = BEST_BITS + CITY_BITS + 2;
  localparam logic [BEST_BITS-1:0] CEIL = BEST_BITS'(SEARCH_CEILING);

  state_t state, state_next;

  logic [COUNT_BITS-1:0] city_count;
  logic [CNT_BITS-1:0]   act_count;
  logic [CITY_BITS-1:0]  last_idx;

  logic [CITY_BITS-1:0] start_table [2**CITY_FIELD_BITS];
  logic [CITY_BITS-1:0] start_idx;

  logic accept, run_go, load_wr, load_ok;

  logic [WEIGHT_BITS-1:0] weight_matrix [MAT_DEPTH];
  logic [WEIGHT_BITS-1:0] mat_rdata;
  logic [CITY_BITS-1:0]   mat_row, mat_col;
  logic [ADDR_BITS-1:0]   mat_rd_addr, mat_wr_addr;

  logic [CITY_BITS-1:0] path_store [MAX_CITIES];
  logic [CITY_BITS-1:0] path_rd_data, path_rd_addr, path_wr_addr, path_wr_data;
  logic                 path_wr_en;

  logic [MAX_CITIES-1:0] visited;
  logic [CITY_BITS-1:0]  cur, sel, scan_j, scan_j_d, step_k, emit_k, prev;
  logic                  scan_pend;
  logic [BEST_BITS-1:0]  best, h0, h1, cand;
  logic [CITY_BITS-1:0]  e0, e1, e2, e3;
  logic [ACC_BITS-1:0]   running, total, hsum;
  logic [TOUR_BITS-1:0]  tour;

  logic [ACC_BITS-1:0] alu_a, alu_b;
  logic                alu_sub;
  logic [ACC_BITS:0]   alu_res;

  logic                 out_load;
  logic [CITY_BITS-1:0] emit_city;

  function automatic logic [ADDR_BITS-1:0] mat_addr(input logic [CITY_BITS-1:0] r,
                                                    input logic [CITY_BITS-1:0] c);
    return ADDR_BITS'(ADDR_BITS'(r) * ADDR_BITS'(MAX_CITIES)) + ADDR_BITS'(c);
  endfunction

  genvar g;
  generate
    for (g = 0; g < 2**CITY_FIELD_BITS; g++) begin : g_start
      assign start_table[g] = CITY_BITS'(g % MAX_CITIES);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RESET;
    end else if (cfg_we) begin
      city_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (city_count == '0) begin
      act_count = CNT_BITS'(1);
    end else if (CLAMP_BITS'(city_count) > CLAMP_BITS'(MAX_CITIES)) begin
      act_count = CNT_BITS'(MAX_CITIES);
    end else begin
      act_count = CNT_BITS'(city_count);
    end
  end

  assign last_idx  = CITY_BITS'(act_count - CNT_BITS'(1));
  assign start_idx = start_table[from_city];
  assign load_ok   = (CLAMP_BITS'(from_city) < CLAMP_BITS'(MAX_CITIES)) &&
                     (CLAMP_BITS'(to_city) < CLAMP_BITS'(MAX_CITIES));
  assign accept    = item_valid && !item_stall;
  assign run_go    = accept && (op == OP_RUN);
  assign load_wr   = accept && (op == OP_LOAD) && load_ok;

  assign mat_wr_addr = mat_addr(CITY_BITS'(from_city), CITY_BITS'(to_city));
  assign mat_rd_addr = mat_addr(mat_row, mat_col);
  assign cand        = BEST_BITS'(mat_rdata);

  assign alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(ACC_BITS + 1){alu_sub}})
                 + (ACC_BITS + 1)'(alu_sub);

  always_ff @(posedge clk) begin
    if (load_wr) begin
      weight_matrix[mat_wr_addr] <= WEIGHT_BITS'(edge_weight);
    end
    mat_rdata <= weight_matrix[mat_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (path_wr_en) begin
      path_store[path_wr_addr] <= path_wr_data;
    end
    path_rd_data <= path_store[path_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (run_go) begin
          state_next = (last_idx == '0) ? S_ADJ_RD1 : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_j == last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:    state_next = S_COMMIT;
      S_COMMIT:   state_next = (step_k == last_idx) ? S_ADJ_RD1 : S_SCAN;
      S_ADJ_RD1:  state_next = S_ADJ_RD2;
      S_ADJ_RD2:  state_next = S_ADJ_ADD2;
      S_ADJ_ADD2: state_next = S_ADJ_HSUM;
      S_ADJ_HSUM: state_next = S_ADJ_DIFF;
      S_ADJ_DIFF: state_next = S_ADJ_SAT;
      S_ADJ_SAT:  state_next = S_EMIT_RD;
      S_EMIT_RD:  state_next = S_EMIT_PUT;
      S_EMIT_PUT: begin
        if (out_load) begin
          state_next = (emit_k == last_idx) ? S_IDLE : S_EMIT_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_stall   = (state != S_IDLE);
    mat_row      = cur;
    mat_col      = scan_j;
    path_wr_en   = 1'b0;
    path_wr_addr = step_k;
    path_wr_data = sel;
    path_rd_addr = emit_k;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        path_wr_en   = run_go;
        path_wr_addr = '0;
        path_wr_data = start_idx;
      end
      S_COMMIT: begin
        path_wr_en = 1'b1;
        alu_a      = running;
        alu_b      = ACC_BITS'(best);
      end
      S_ADJ_RD1: begin
        mat_row = e0;
        mat_col = e3;
      end
      S_ADJ_RD2: begin
        mat_row = e2;
        mat_col = e1;
        alu_a   = running;
        alu_b   = ACC_BITS'(mat_rdata);
      end
      S_ADJ_ADD2: begin
        alu_a = total;
        alu_b = ACC_BITS'(mat_rdata);
      end
      S_ADJ_HSUM: begin
        alu_a = ACC_BITS'(h0);
        alu_b = ACC_BITS'(h1);
      end
      S_ADJ_DIFF: begin
        alu_a   = total;
        alu_b   = hsum;
        alu_sub = 1'b1;
      end
      S_EMIT_PUT: begin
        out_load = !result_valid || !result_stall;
      end
      default: begin
      end
    endcase
  end

  // heaviest-edge swap applied on the way out, in path order
  always_comb begin
    emit_city = path_rd_data;
    if (emit_k != '0) begin
      if (prev == e0 && emit_city == e1) begin
        emit_city = e3;
      end
      if (prev == e2 && emit_city == e3) begin
        emit_city = e1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited   <= '0;
      scan_pend <= 1'b0;
      scan_j    <= '0;
      step_k    <= '0;
      emit_k    <= '0;
      h0        <= '0;
      h1        <= '0;
      e0        <= '0;
      e1        <= '0;
      e2        <= '0;
      e3        <= '0;
      running   <= '0;
    end else begin
      scan_pend <= (state == S_SCAN);
      scan_j_d  <= scan_j;
      if (scan_pend && !visited[scan_j_d] && cand < best) begin
        best <= cand;
        sel  <= scan_j_d;
      end
      case (state)
        S_IDLE: begin
          if (run_go) begin
            cur <= start_idx;
            for (int i = 0; i < MAX_CITIES; i++) begin
              visited[i] <= (CITY_BITS'(i) == start_idx);
            end
            h0      <= '0;
            h1      <= '0;
            e0      <= '0;
            e1      <= '0;
            e2      <= '0;
            e3      <= '0;
            running <= '0;
            best    <= CEIL;
            sel     <= '0;
            step_k  <= CITY_BITS'(1);
            scan_j  <= '0;
          end
        end
        S_SCAN: scan_j <= scan_j + CITY_BITS'(1);
        S_COMMIT: begin
          if (h0 < best) begin
            h1 <= h0;
            h0 <= best;
            e2 <= e0;
            e3 <= e1;
            e0 <= cur;
            e1 <= sel;
          end else if (h1 < best) begin
            h1 <= best;
            e2 <= cur;
            e3 <= sel;
          end
          cur          <= sel;
          running      <= alu_res[ACC_BITS-1:0];
          visited[sel] <= 1'b1;
          step_k       <= step_k + CITY_BITS'(1);
          scan_j       <= '0;
          best         <= CEIL;
          sel          <= '0;
        end
        S_ADJ_RD2:  total <= alu_res[ACC_BITS-1:0];
        S_ADJ_ADD2: total <= alu_res[ACC_BITS-1:0];
        S_ADJ_HSUM: hsum  <= alu_res[ACC_BITS-1:0];
        S_ADJ_DIFF: total <= alu_res[ACC_BITS] ? '0 : alu_res[ACC_BITS-1:0];
        S_ADJ_SAT: begin
          tour   <= (total > ACC_BITS'(TOUR_WEIGHT_MAX)) ? TOUR_WEIGHT_MAX
                                                         : total[TOUR_BITS-1:0];
          emit_k <= '0;
        end
        S_EMIT_PUT: begin
          if (out_load) begin
            prev   <= emit_city;
            emit_k <= emit_k + CITY_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      position    <= POS_BITS'(emit_k);
      city        <= CITY_FIELD_BITS'(emit_city);
      last        <= (emit_k == last_idx);
      tour_weight <= (emit_k == last_idx) ? tour : '0;
    end
  end

`ifndef ASSERT_OFF
  a_heaviest_order: assert property (@(posedge clk) disable iff (rst)
    h1 <= h0)
    else $error("second heaviest edge above heaviest");

  a_pick_unvisited: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && best != CEIL) |-> !visited[sel])
    else $error("chosen city already visited");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && best != CEIL) |-> (sel <= last_idx))
    else $error("chosen city beyond active count");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> (position == POS_BITS'(last_idx)))
    else $error("last item not at final path position");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_j <= last_idx))
    else $error("scan index past active count");
`endif

endmodule
`default_nettype wire

FILE: bench/tour_checker.sv
// Checker for the nearest-neighbour tour builder: tracks the matrix, predicts tours, compares.
`timescale 1ns / 1ps
module tour_checker
  import nntb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [COUNT_BITS-1:0]      cfg_wdata,
  input  logic                       item_valid,
  input  logic                       item_stall,
  input  logic                       op,
  input  logic [CITY_FIELD_BITS-1:0] from_city,
  input  logic [CITY_FIELD_BITS-1:0] to_city,
  input  logic [EDGE_FIELD_BITS-1:0] edge_weight,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic [POS_BITS-1:0]        position,
  input  logic [CITY_FIELD_BITS-1:0] city,
  input  logic [TOUR_BITS-1:0]       tour_weight,
  input  logic                       last,
  output int                         pending,
  output int                         fail_count,
  output int                         checked
);

  localparam int CITIES = DEF_MAX_CITIES;

  typedef struct packed {
    logic [POS_BITS-1:0]        pos;
    logic [CITY_FIELD_BITS-1:0] city;
    logic [TOUR_BITS-1:0]       weight;
    logic                       last;
  } tour_stop_t;

  logic [EDGE_FIELD_BITS-1:0] weights [CITIES][CITIES];
  logic [COUNT_BITS-1:0]      count_reg = CITY_COUNT_RESET;
  tour_stop_t                 tour_q [$];
  int                         errs = 0;
  int                         n_checked = 0;

  task automatic predict_tour(input logic [CITY_FIELD_BITS-1:0] start);
    int n, k, j, here, pick;
    longint unsigned best, total, sub;
    longint unsigned top_w [2];
    int top_end [4];
    bit seen [CITIES];
    int route [CITIES];
    tour_stop_t stop;
    n = (count_reg == 0) ? 1 : (count_reg > CITIES) ? CITIES : int'(count_reg);
    for (k = 0; k < CITIES; k++) seen[k] = 1'b0;
    top_w[0] = 0;
    top_w[1] = 0;
    for (k = 0; k < 4; k++) top_end[k] = 0;
    total = 0;
    here = int'(start);
    seen[here] = 1'b1;
    route[0] = here;
    for (k = 1; k < n; k++) begin
      best = SEARCH_CEILING;
      pick = 0;
      for (j = 0; j < n; j++)
        if (!seen[j] && 64'(weights[here][j]) < best) begin
          best = 64'(weights[here][j]);
          pick = j;
        end
      if (top_w[0] < best) begin
        top_w[1] = top_w[0];
        top_w[0] = best;
        top_end[2] = top_end[0];
        top_end[3] = top_end[1];
        top_end[0] = here;
        top_end[1] = pick;
      end else if (top_w[1] < best) begin
        top_w[1] = best;
        top_end[2] = here;
        top_end[3] = pick;
      end
      here = pick;
      total += best;
      route[k] = pick;
      seen[pick] = 1'b1;
    end
    // swap pass over the heaviest and second-heaviest edges, in path order
    for (k = 1; k < n; k++) begin
      if (route[k-1] == top_end[0] && route[k] == top_end[1]) route[k] = top_end[3];
      if (route[k-1] == top_end[2] && route[k] == top_end[3]) route[k] = top_end[1];
    end
    total += 64'(weights[top_end[0]][top_end[3]]);
    total += 64'(weights[top_end[2]][top_end[1]]);
    sub = top_w[0] + top_w[1];
    total = (total > sub) ? total - sub : 0;
    if (total > 64'(TOUR_WEIGHT_MAX)) total = 64'(TOUR_WEIGHT_MAX);
    for (k = 0; k < n; k++) begin
      stop.pos    = POS_BITS'(k);
      stop.city   = CITY_FIELD_BITS'(route[k]);
      stop.last   = (k + 1 == n);
      stop.weight = stop.last ? TOUR_BITS'(total) : '0;
      tour_q.insert(tour_q.size(), stop);
    end
  endtask

  always @(posedge clk) begin
    tour_stop_t exp_stop, got_stop;
    if (rst) begin
      count_reg = CITY_COUNT_RESET;
      tour_q.delete();
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      if (item_valid && !item_stall) begin
        if (op == OP_LOAD) weights[from_city][to_city] = edge_weight;
        else predict_tour(from_city);
      end
      if (result_valid && !result_stall) begin
        got_stop = {position, city, tour_weight, last};
        if (tour_q.size() == 0) begin
          $display("%0t: unexpected item pos %0d city %0d weight %0d last %0b",
                   $time, position, city, tour_weight, last);
          errs++;
        end else begin
          exp_stop = tour_q.pop_front();
          if (got_stop !== exp_stop) begin
            $display("%0t: expected pos %0d city %0d weight %0d last %0b", $time,
                     exp_stop.pos, exp_stop.city, exp_stop.weight, exp_stop.last);
            $display("%0t: actual   pos %0d city %0d weight %0d last %0b", $time,
                     position, city, tour_weight, last);
            errs++;
          end
          n_checked++;
        end
      end
    end
    pending    <= tour_q.size();
    fail_count <= errs;
    checked    <= n_checked;
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the nearest-neighbour tour builder: stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module tb_top
  import nntb_pkg::*;
();

  localparam int CITIES        = DEF_MAX_CITIES;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 420;
  localparam int HOLD_CYCLES   = 2500;
  localparam int DRAIN_LIMIT   = 200000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [COUNT_BITS-1:0]      cfg_wdata = '0;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic                       op = OP_LOAD;
  logic [CITY_FIELD_BITS-1:0] from_city = '0;
  logic [CITY_FIELD_BITS-1:0] to_city = '0;
  logic [EDGE_FIELD_BITS-1:0] edge_weight = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [POS_BITS-1:0]        position;
  logic [CITY_FIELD_BITS-1:0] city;
  logic [TOUR_BITS-1:0]       tour_weight;
  logic                       last;
  int                         pending, fail_count, checked;

  logic [EDGE_FIELD_BITS-1:0] tri_w [9] = '{16'd0, 16'd7, 16'd7,
                                           16'd3, 16'd0, 16'd0,
                                           16'hFFFF, 16'd9, 16'd0};
  bit written [CITIES][CITIES];
  int active_n = CITIES;
  int burst_left = 0;
  int loads_sent = 0;
  int builds_sent = 0;
  int settings = 0;
  bit long_hold_req = 1'b0;

  always #6 clk = ~clk;

  nearest_neighbour_tour_builder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_valid(item_valid), .item_stall(item_stall), .op(op),
    .from_city(from_city), .to_city(to_city), .edge_weight(edge_weight),
    .result_valid(result_valid), .result_stall(result_stall),
    .position(position), .city(city), .tour_weight(tour_weight), .last(last)
  );

  tour_checker u_tour_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_valid(item_valid), .item_stall(item_stall), .op(op),
    .from_city(from_city), .to_city(to_city), .edge_weight(edge_weight),
    .result_valid(result_valid), .result_stall(result_stall),
    .position(position), .city(city), .tour_weight(tour_weight), .last(last),
    .pending(pending), .fail_count(fail_count), .checked(checked)
  );

  // receiver: random stall segments, plus one long hold when asked
  initial begin
    int mode, len;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len = $urandom_range(20, 150);
        repeat (len) begin
          case (mode)
            0: result_stall <= 1'b0;
            1: result_stall <= 1'($urandom_range(0, 1));
            default: result_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [EDGE_FIELD_BITS-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return EDGE_FIELD_BITS'($urandom_range(0, 3));
      default: return EDGE_FIELD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic o, input int f, input int t,
                           input logic [EDGE_FIELD_BITS-1:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
    end
    item_valid  <= 1'b1;
    op          <= o;
    from_city   <= CITY_FIELD_BITS'(f);
    to_city     <= CITY_FIELD_BITS'(t);
    edge_weight <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left--;
    if (o == OP_LOAD) begin
      written[f][t] = 1'b1;
      loads_sent++;
    end else begin
      builds_sent++;
    end
  endtask

  // loads every entry the build can read that is still unwritten, then sends it
  task automatic send_build(input int start, input bit hold);
    int r, c;
    for (r = 0; r < CITIES; r++)
      if (r < active_n || r == start)
        for (c = 0; c < active_n; c++)
          if (!written[r][c]) send_item(OP_LOAD, r, c, pick_weight());
    if (hold) long_hold_req = 1'b1;
    send_item(OP_RUN, start, $urandom_range(0, CITIES - 1), EDGE_FIELD_BITS'($urandom));
  endtask

  task automatic set_count(input int v);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_BITS'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    burst_left = 0;
    active_n = (v == 0) ? 1 : (v > CITIES) ? CITIES : v;
    settings++;
  endtask

  initial begin
    int i, phase, cnt, len, f, t, random_sent, drain;
    random_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count 0 acts as one city; start above the count
    set_count(0);
    send_item(OP_LOAD, 0, 0, '1);
    send_build(0, 1'b0);
    send_build(31, 1'b0);
    // three cities: ties, zero edges, heavy edge, non-permutation after the swap
    set_count(3);
    for (i = 0; i < 9; i++) send_item(OP_LOAD, i / 3, i % 3, tri_w[i]);
    send_item(OP_LOAD, 31, 31, '0);
    send_build(0, 1'b0);
    send_build(1, 1'b0);
    send_build(2, 1'b0);
    send_build(30, 1'b0);

    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: cnt = 63;
        1: cnt = 32;
        2: cnt = 1;
        3: cnt = 2;
        default:
          case ($urandom_range(0, 19))
            0: cnt = 0;
            1: cnt = $urandom_range(33, 63);
            2, 3, 4: cnt = $urandom_range(25, 32);
            5, 6, 7, 8, 9, 10: cnt = $urandom_range(9, 24);
            default: cnt = $urandom_range(1, 8);
          endcase
      endcase
      set_count(cnt);
      // first full-size phase: long output hold while items keep coming
      if (phase == 0) begin
        send_build(0, 1'b1);
        random_sent++;
      end
      len = $urandom_range(12, 40);
      repeat (len) begin
        if ($urandom_range(0, 3) == 0) begin
          f = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CITIES - 1)
                                          : $urandom_range(0, active_n - 1);
          send_build(f, 1'b0);
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            f = $urandom_range(0, CITIES - 1);
            t = $urandom_range(0, CITIES - 1);
          end else begin
            f = $urandom_range(0, active_n - 1);
            t = $urandom_range(0, active_n - 1);
          end
          send_item(OP_LOAD, f, t, pick_weight());
        end
        random_sent++;
      end
      phase++;
    end

    item_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending != 0) begin
      $display("tb_top: FAIL");
    end else begin
      repeat (50) @(posedge clk);
      $display("summary: %0d weight loads, %0d tour builds, %0d result items checked",
               loads_sent, builds_sent, checked);
      $display("summary: %0d city-count settings incl. 0 and above 32, one long output hold",
               settings);
      if (fail_count == 0) begin
        $display("tb_top: PASS");
      end else begin
        $display("tb_top: FAIL");
      end
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
